// ===== rtl/core/ptfr_pkg.sv =====
// ----------------------------------------------------------------------------
// ptfr_pkg
// Shared constants, microcode types and the control store for the paged
// translation block with FIFO / random frame replacement.
// ----------------------------------------------------------------------------
package ptfr_pkg;

    localparam int PID_W       = 2;
    localparam int ADDR_W      = 13;
    localparam int PICK_W      = 2;
    localparam int FRAME_OUT_W = 2;
    localparam int VPAGE_W     = 2;
    localparam int PHYS_W      = 12;
    localparam int CNT_W       = 32;
    localparam int TIME_W      = 32;
    localparam int THOU_W      = 4;
    localparam int OFS_W       = 10;
    localparam int PAGE_SPAN   = 1000;
    localparam int MAX_THOU    = 8;

    localparam int DEF_FRAME_COUNT       = 4;
    localparam int DEF_NUM_PROCESSES     = 3;
    localparam int DEF_PAGES_PER_PROCESS = 4;

    localparam int APB_DW = 32;
    localparam int APB_AW = 3;
    localparam logic [APB_AW-3:0] REG_MODE = '0;

    localparam logic MODE_FIFO   = 1'b0;
    localparam logic MODE_RANDOM = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK,
        S_TEST_HIT,
        S_TEST_FULL,
        S_TEST_MODE,
        S_RAND,
        S_SCAN_START,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SET_BEST,
        S_EVICT_RD,
        S_EVICT,
        S_LOAD,
        S_FREE,
        S_HIT,
        S_REPORT
    } t_step;

    typedef enum logic [3:0] {
        C_NEXT,
        C_JUMP,
        C_NO_ACCEPT,
        C_INVALID,
        C_HIT,
        C_NOT_FULL,
        C_FIFO,
        C_MORE,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        logic  in_ready;
        logic  scan_clr;
        logic  scan_rd;
        logic  scan_cmp;
        logic  vic_best;
        logic  vic_rand;
        logic  vic_free;
        logic  evict;
        logic  load;
        logic  hit;
        logic  report;
        t_cond cond;
        t_step target;
    } t_uop;

    typedef struct packed {
        logic accept;
        logic invalid;
        logic hit;
        logic not_full;
        logic fifo;
        logic more;
        logic out_busy;
    } t_flags;

    // control store: one word per step, jump to target when cond holds
    function automatic t_uop ucode(t_step s);
        t_uop u;
        u        = '0;
        u.cond   = C_NEXT;
        u.target = S_IDLE;
        unique case (s)
            S_IDLE: begin
                u.in_ready = 1'b1;
                u.cond     = C_NO_ACCEPT;
                u.target   = S_IDLE;
            end
            S_LOOK: begin
                u.cond   = C_INVALID;
                u.target = S_REPORT;
            end
            S_TEST_HIT: begin
                u.cond   = C_HIT;
                u.target = S_HIT;
            end
            S_TEST_FULL: begin
                u.cond   = C_NOT_FULL;
                u.target = S_FREE;
            end
            S_TEST_MODE: begin
                u.cond   = C_FIFO;
                u.target = S_SCAN_START;
            end
            S_RAND: begin
                u.vic_rand = 1'b1;
                u.cond     = C_JUMP;
                u.target   = S_EVICT_RD;
            end
            S_SCAN_START: begin
                u.scan_clr = 1'b1;
            end
            S_SCAN_RD: begin
                u.scan_rd = 1'b1;
            end
            S_SCAN_CMP: begin
                u.scan_cmp = 1'b1;
                u.cond     = C_MORE;
                u.target   = S_SCAN_RD;
            end
            S_SET_BEST: begin
                u.vic_best = 1'b1;
            end
            S_EVICT_RD: begin
                u.cond = C_NEXT;
            end
            S_EVICT: begin
                u.evict = 1'b1;
            end
            S_LOAD: begin
                u.load   = 1'b1;
                u.cond   = C_JUMP;
                u.target = S_REPORT;
            end
            S_FREE: begin
                u.vic_free = 1'b1;
                u.cond     = C_JUMP;
                u.target   = S_LOAD;
            end
            S_HIT: begin
                u.hit = 1'b1;
            end
            S_REPORT: begin
                u.report = 1'b1;
                u.cond   = C_OUT_BUSY;
                u.target = S_REPORT;
            end
        endcase
        return u;
    endfunction

    // thousands digit of a decimal address
    function automatic logic [THOU_W-1:0] thousands(logic [ADDR_W-1:0] va);
        logic [THOU_W-1:0] t;
        t = '0;
        for (int k = 1; k <= MAX_THOU; k++) begin
            if (va >= ADDR_W'(k * PAGE_SPAN)) begin
                t = THOU_W'(k);
            end
        end
        return t;
    endfunction

    function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [1:0] n);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {{(CNT_W-1){1'b0}}, n};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

// ===== rtl/core/ptfr_if.sv =====
// ----------------------------------------------------------------------------
// ptfr_in_if / ptfr_out_if
// Valid/ready channels for access requests and translation results.
// ----------------------------------------------------------------------------
interface ptfr_in_if;
    import ptfr_pkg::*;

    logic              valid;
    logic              ready;
    logic [PID_W-1:0]  process_id;
    logic [ADDR_W-1:0] virtual_address;
    logic [PICK_W-1:0] random_frame;

    modport source (output valid, output process_id, output virtual_address,
                    output random_frame, input ready);
    modport sink   (input valid, input process_id, input virtual_address,
                    input random_frame, output ready);
endinterface

interface ptfr_out_if;
    import ptfr_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   page_fault;
    logic [FRAME_OUT_W-1:0] frame_number;
    logic [PHYS_W-1:0]      physical_address;
    logic                   evicted;
    logic [PID_W-1:0]       victim_process;
    logic [VPAGE_W-1:0]     victim_page;
    logic [CNT_W-1:0]       fault_total;
    logic [CNT_W-1:0]       access_total;

    modport source (output valid, output page_fault, output frame_number,
                    output physical_address, output evicted, output victim_process,
                    output victim_page, output fault_total, output access_total,
                    input ready);
    modport sink   (input valid, input page_fault, input frame_number,
                    input physical_address, input evicted, input victim_process,
                    input victim_page, input fault_total, input access_total,
                    output ready);
endinterface

// ===== rtl/core/paged_translation_with_fifo_replace_top.sv =====
// ----------------------------------------------------------------------------
// paged_translation_with_fifo_replace_top
// Per-process page lookup with load on fault and FIFO or random eviction.
//
//   channel  dir  handshake          contents
//   i_in     in   valid/ready        process_id, virtual_address, random_frame
//   o_out    out  valid/ready        fault, frame, physical address, victim, totals
//   apb      in   psel/penable       replacement_mode at byte address 0
//
// One item at a time; each access runs from the transfer step through the report step
//   on one of five paths: invalid, hit, fault into a free frame, random eviction,
//   or FIFO eviction (the oldest-frame scan reads each frame entry through the
//   frame table port in a read step and compares it in a compare step).
// A held result does not block the next transfer; the following access waits
// in its report step until the held result is taken.
// Synchronous active-low reset clears present bits, counters and the sequencer.
// ----------------------------------------------------------------------------
module paged_translation_with_fifo_replace_top #(
    parameter int FRAME_COUNT       = ptfr_pkg::DEF_FRAME_COUNT,
    parameter int NUM_PROCESSES     = ptfr_pkg::DEF_NUM_PROCESSES,
    parameter int PAGES_PER_PROCESS = ptfr_pkg::DEF_PAGES_PER_PROCESS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ptfr_in_if.sink                       i_in,
    ptfr_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ptfr_pkg::APB_AW-1:0]   paddr,
    input  logic [ptfr_pkg::APB_DW-1:0]   pwdata,
    output logic [ptfr_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import ptfr_pkg::*;

    logic   r_mode;
    t_uop   uop;
    t_flags flags;

    assign pready = 1'b1;
    assign prdata = (paddr[APB_AW-1:2] == REG_MODE) ? APB_DW'(r_mode) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_FIFO;
        end else if (psel && penable && pwrite && pready
                     && (paddr[APB_AW-1:2] == REG_MODE)) begin
            r_mode <= pwdata[0];
        end
    end

    ptfr_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uop   (uop)
    );

    ptfr_dp #(
        .FRAME_COUNT       (FRAME_COUNT),
        .NUM_PROCESSES     (NUM_PROCESSES),
        .PAGES_PER_PROCESS (PAGES_PER_PROCESS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_uop              (uop),
        .i_mode             (r_mode),
        .i_in_valid         (i_in.valid),
        .i_process_id       (i_in.process_id),
        .i_virtual_address  (i_in.virtual_address),
        .i_random_frame     (i_in.random_frame),
        .o_in_ready         (i_in.ready),
        .i_out_ready        (o_out.ready),
        .o_out_valid        (o_out.valid),
        .o_page_fault       (o_out.page_fault),
        .o_frame_number     (o_out.frame_number),
        .o_physical_address (o_out.physical_address),
        .o_evicted          (o_out.evicted),
        .o_victim_process   (o_out.victim_process),
        .o_victim_page      (o_out.victim_page),
        .o_fault_total      (o_out.fault_total),
        .o_access_total     (o_out.access_total),
        .o_flags            (flags)
    );

endmodule

// ===== rtl/core/ptfr_seq.sv =====
// ----------------------------------------------------------------------------
// ptfr_seq
// Step counter and control store; evaluates the jump condition of each word.
// ----------------------------------------------------------------------------
module ptfr_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ptfr_pkg::t_flags i_flags,
    output ptfr_pkg::t_uop   o_uop
);
    import ptfr_pkg::*;

    t_step r_step, n_step;
    t_uop  uop;
    logic  take;

    assign uop   = ucode(r_step);
    assign o_uop = uop;

    always_comb begin
        unique case (uop.cond)
            C_NEXT:      take = 1'b0;
            C_JUMP:      take = 1'b1;
            C_NO_ACCEPT: take = !i_flags.accept;
            C_INVALID:   take = i_flags.invalid;
            C_HIT:       take = i_flags.hit;
            C_NOT_FULL:  take = i_flags.not_full;
            C_FIFO:      take = i_flags.fifo;
            C_MORE:      take = i_flags.more;
            C_OUT_BUSY:  take = i_flags.out_busy;
            default:     take = 1'b0;
        endcase
        // REPORT is the last word; falling through wraps to IDLE
        n_step = take ? uop.target : t_step'(r_step + 4'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// ===== rtl/core/ptfr_dp.sv =====
// ----------------------------------------------------------------------------
// ptfr_dp
// Datapath: request latch, page tables, frame table, scan unit, counters and
// result register, all driven by the control word.
// ----------------------------------------------------------------------------
module ptfr_dp #(
    parameter int FRAME_COUNT       = ptfr_pkg::DEF_FRAME_COUNT,
    parameter int NUM_PROCESSES     = ptfr_pkg::DEF_NUM_PROCESSES,
    parameter int PAGES_PER_PROCESS = ptfr_pkg::DEF_PAGES_PER_PROCESS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ptfr_pkg::t_uop                      i_uop,
    input  logic                                i_mode,
    input  logic                                i_in_valid,
    input  logic [ptfr_pkg::PID_W-1:0]          i_process_id,
    input  logic [ptfr_pkg::ADDR_W-1:0]         i_virtual_address,
    input  logic [ptfr_pkg::PICK_W-1:0]         i_random_frame,
    output logic                                o_in_ready,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic                                o_page_fault,
    output logic [ptfr_pkg::FRAME_OUT_W-1:0]    o_frame_number,
    output logic [ptfr_pkg::PHYS_W-1:0]         o_physical_address,
    output logic                                o_evicted,
    output logic [ptfr_pkg::PID_W-1:0]          o_victim_process,
    output logic [ptfr_pkg::VPAGE_W-1:0]        o_victim_page,
    output logic [ptfr_pkg::CNT_W-1:0]          o_fault_total,
    output logic [ptfr_pkg::CNT_W-1:0]          o_access_total,
    output ptfr_pkg::t_flags                    o_flags
);
    import ptfr_pkg::*;

    localparam int TBL  = NUM_PROCESSES * PAGES_PER_PROCESS;
    localparam int SW   = (TBL > 1) ? $clog2(TBL) : 1;
    localparam int PW   = (PAGES_PER_PROCESS > 1) ? $clog2(PAGES_PER_PROCESS) : 1;
    localparam int FW   = $clog2(FRAME_COUNT);
    localparam int CW   = $clog2(FRAME_COUNT + 1);
    localparam int FE_W = PID_W + PW + TIME_W;

    // request latch
    logic              r_valid;
    logic [PID_W-1:0]  r_pid;
    logic [PW-1:0]     r_page;
    logic [OFS_W-1:0]  r_ofs;
    logic [SW-1:0]     r_slot;
    logic [PICK_W-1:0] r_pick;

    // page tables
    logic [TBL-1:0]    r_present;
    logic [FW-1:0]     pf_mem [TBL];
    logic [FW-1:0]     r_pf_rd;

    // frame table
    logic [FE_W-1:0]   f_mem [FRAME_COUNT];
    logic [FE_W-1:0]   r_fdata;
    logic [FW-1:0]     f_addr;
    logic [PID_W-1:0]  fd_owner;
    logic [PW-1:0]     fd_page;
    logic [TIME_W-1:0] fd_time;

    // scan and victim
    logic [CW-1:0]     r_scan;
    logic [CW-1:0]     scan_prev;
    logic [FW-1:0]     r_best;
    logic [TIME_W-1:0] r_best_time;
    logic [FW-1:0]     r_victim;
    logic [CW-1:0]     r_in_use;
    logic              vic_ok;
    logic [SW-1:0]     vic_slot;

    // counters and per-item result
    logic [TIME_W-1:0] r_time;
    logic [CNT_W-1:0]  r_fault_cnt;
    logic [CNT_W-1:0]  r_access_cnt;
    logic              r_fault;
    logic [FW-1:0]     r_frame;
    logic              r_ev;
    logic [PID_W-1:0]  r_vproc;
    logic [PW-1:0]     r_vpage;

    // request decode
    logic [THOU_W-1:0] in_thou;
    logic              in_ok;
    logic              accept;
    logic              out_busy;

    assign in_thou = thousands(i_virtual_address);
    assign in_ok   = (i_process_id != '0) && (32'(i_process_id) <= NUM_PROCESSES)
                   && (in_thou != '0) && (32'(in_thou) - 1 < PAGES_PER_PROCESS);

    assign o_in_ready = i_uop.in_ready;
    assign accept     = i_in_valid && i_uop.in_ready;
    assign out_busy   = o_out_valid && !i_out_ready;

    assign fd_owner = r_fdata[FE_W-1 -: PID_W];
    assign fd_page  = r_fdata[TIME_W +: PW];
    assign fd_time  = r_fdata[TIME_W-1:0];
    assign f_addr   = i_uop.scan_rd ? r_scan[FW-1:0] : r_victim;
    assign scan_prev = r_scan - CW'(1);

    assign vic_ok   = (fd_owner != '0) && (32'(fd_owner) <= NUM_PROCESSES)
                    && (32'(fd_page) < PAGES_PER_PROCESS);
    assign vic_slot = SW'((32'(fd_owner) - 1) * PAGES_PER_PROCESS + 32'(fd_page));

    always_comb begin
        o_flags.accept   = accept;
        o_flags.invalid  = !r_valid;
        o_flags.hit      = r_present[r_slot];
        o_flags.not_full = 32'(r_in_use) < FRAME_COUNT;
        o_flags.fifo     = (i_mode == MODE_FIFO);
        o_flags.more     = 32'(r_scan) != FRAME_COUNT;
        o_flags.out_busy = out_busy;
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_uop.load) begin
            pf_mem[r_slot]  <= r_victim;
            f_mem[r_victim] <= {r_pid, r_page, r_time + TIME_W'(1)};
        end
        r_pf_rd <= pf_mem[r_slot];
        r_fdata <= f_mem[f_addr];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pid   <= i_process_id;
            r_pick  <= i_random_frame;
            r_page  <= PW'(32'(in_thou) - 1);
            r_ofs   <= OFS_W'(32'(i_virtual_address) - 32'(in_thou) * PAGE_SPAN);
            r_slot  <= in_ok ? SW'((32'(i_process_id) - 1) * PAGES_PER_PROCESS
                                   + 32'(in_thou) - 1) : '0;
            r_fault <= 1'b0;
            r_frame <= '0;
            r_ev    <= 1'b0;
            r_vproc <= '0;
            r_vpage <= '0;
        end
        if (i_uop.scan_clr) begin
            r_scan <= '0;
        end
        if (i_uop.scan_rd) begin
            r_scan <= r_scan + CW'(1);
        end
        if (i_uop.scan_cmp && ((r_scan == CW'(1)) || (fd_time < r_best_time))) begin
            r_best      <= scan_prev[FW-1:0];
            r_best_time <= fd_time;
        end
        if (i_uop.vic_best) begin
            r_victim <= r_best;
        end
        if (i_uop.vic_rand) begin
            r_victim <= FW'((32'(r_pick) >= FRAME_COUNT) ? 32'(r_pick) - FRAME_COUNT
                                                          : 32'(r_pick));
        end
        if (i_uop.vic_free) begin
            r_victim <= r_in_use[FW-1:0];
        end
        if (i_uop.evict) begin
            r_ev    <= 1'b1;
            r_vproc <= fd_owner;
            r_vpage <= fd_page;
        end
        if (i_uop.load) begin
            r_fault <= 1'b1;
            r_frame <= r_victim;
        end
        if (i_uop.hit) begin
            r_frame <= r_pf_rd;
        end
        if (i_uop.report && !out_busy) begin
            o_page_fault       <= r_fault;
            o_frame_number     <= FRAME_OUT_W'(r_frame);
            o_physical_address <= r_valid ? PHYS_W'(32'(r_frame) * PAGE_SPAN + 32'(r_ofs))
                                          : '0;
            o_evicted          <= r_ev;
            o_victim_process   <= r_vproc;
            o_victim_page      <= VPAGE_W'(r_vpage);
            o_fault_total      <= r_fault_cnt;
            o_access_total     <= r_access_cnt;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_present    <= '0;
            r_in_use     <= '0;
            r_time       <= '0;
            r_fault_cnt  <= '0;
            r_access_cnt <= '0;
            o_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_valid <= in_ok;
            end
            if (i_uop.evict) begin
                if (vic_ok) begin
                    r_present[vic_slot] <= 1'b0;
                end
                r_access_cnt <= sat_add(r_access_cnt, 2'd3);
            end
            if (i_uop.vic_free) begin
                r_in_use     <= r_in_use + CW'(1);
                r_access_cnt <= sat_add(r_access_cnt, 2'd2);
            end
            if (i_uop.hit) begin
                r_time       <= r_time + TIME_W'(1);
                r_access_cnt <= sat_add(r_access_cnt, 2'd1);
            end
            if (i_uop.load) begin
                r_present[r_slot] <= 1'b1;
                r_time            <= r_time + TIME_W'(1);
                r_fault_cnt       <= sat_add(r_fault_cnt, 2'd1);
            end
            if (i_uop.report && !out_busy) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/core/ptfr_checker.sv =====
// ----------------------------------------------------------------------------
// ptfr_checker
// Port-level checks for the translation block, bound to the top level.
// ----------------------------------------------------------------------------
module ptfr_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic                              i_page_fault,
    input logic [ptfr_pkg::FRAME_OUT_W-1:0]  i_frame_number,
    input logic [ptfr_pkg::PHYS_W-1:0]       i_physical_address,
    input logic                              i_evicted,
    input logic [ptfr_pkg::PID_W-1:0]        i_victim_process,
    input logic [ptfr_pkg::VPAGE_W-1:0]      i_victim_page,
    input logic [ptfr_pkg::CNT_W-1:0]        i_fault_total,
    input logic [ptfr_pkg::CNT_W-1:0]        i_access_total
);
    import ptfr_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_physical_address)
            && $stable(i_frame_number) && $stable(i_fault_total)
            && $stable(i_access_total))
        else $error("result changed while stalled");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second transfer taken while an access is in flight");

    a_evict_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_evicted |-> i_page_fault)
        else $error("eviction reported without a fault");

    a_no_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_evicted |-> (i_victim_process == '0) && (i_victim_page == '0))
        else $error("victim fields set without eviction");

endmodule

bind paged_translation_with_fifo_replace_top ptfr_checker u_ptfr_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in.valid),
    .i_in_ready         (i_in.ready),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_page_fault       (o_out.page_fault),
    .i_frame_number     (o_out.frame_number),
    .i_physical_address (o_out.physical_address),
    .i_evicted          (o_out.evicted),
    .i_victim_process   (o_out.victim_process),
    .i_victim_page      (o_out.victim_page),
    .i_fault_total      (o_out.fault_total),
    .i_access_total     (o_out.access_total)
);
